/* hdl/interval_timing_statistics_assert.svh */
// Assertion macros used by the interval timing statistics top level.
`ifndef INTERVAL_TIMING_STATISTICS_ASSERT_SVH
`define INTERVAL_TIMING_STATISTICS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("interval timing statistics: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ITS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("interval timing statistics: next-cycle check failed");

`endif

/* hdl/itstat_pkg.sv */
// Shared constants and types of the interval timing statistics block.
package itstat_pkg;

  // Default width of the tick counter that is measured
  localparam int ITS_STAMP_WIDTH = 32;

  // Event kinds carried on the input tuser
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Field and bus widths
  localparam int FIELD_W    = 32;
  localparam int WIDE_W     = 64;
  localparam int UNIT_W     = 34;
  localparam int OUT_DATA_W = 168;

  // Iteration counts of the shared compare-subtract unit
  localparam int DIV_STEPS  = 64;
  localparam int ROOT_STEPS = 32;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);

  // Result of the shared compare-subtract unit
  typedef struct packed {
    logic              ge;
    logic [UNIT_W-1:0] diff;
  } cmpsub_res_t;

endpackage

/* hdl/itstat_mul.sv */
// Registered 32 by 32 multiplier used for squaring a duration and the mean.
module itstat_mul import itstat_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [FIELD_W-1:0] a,
  input  logic [FIELD_W-1:0] b,
  output logic [WIDE_W-1:0]  prod
);

  // Capture the product when enabled, hold otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= WIDE_W'(a) * WIDE_W'(b);
    end
  end

endmodule

/* hdl/itstat_cmpsub.sv */
// Shared compare-subtract unit: one step of restoring divide or square root.
module itstat_cmpsub import itstat_pkg::*; (
  input  logic [UNIT_W-1:0] a,
  input  logic [UNIT_W-1:0] b,
  output cmpsub_res_t       res
);

  logic [UNIT_W:0] wide_diff;

  // Borrow out of the subtract tells whether a is below b
  assign wide_diff = {1'b0, a} - {1'b0, b};
  assign res.ge    = ~wide_diff[UNIT_W];
  assign res.diff  = wide_diff[UNIT_W-1:0];

endmodule

/* hdl/interval_timing_statistics.sv */
// Top level of the interval timing statistics block: sequencer and state.
//
//  channel  dir  handshake               payload
//  s_*      in   s_tvalid / s_tready     s_tuser mode, s_tdata timestamp
//  m_*      out  m_tvalid / m_tready     m_tdata count, min, max, mean, stddev, flag
//
// A start, clear or unused event is handled in idle. An end event steps from SQ
// through the two divides and the root to OUT, loads its result there and returns
// to idle, where the input is ready again: the one compare-subtract unit runs 64
// steps for the mean divide, 64 for the mean-square divide and 32 for the root.
// Reset clears all statistics at once; there is no clearing pass. s_tready is high
// only while the sequencer is idle. A result waits in the output register; the next
// event is accepted meanwhile; a further end stalls in OUT until that beat is taken.
module interval_timing_statistics import itstat_pkg::*; #(
  parameter int STAMP_WIDTH = ITS_STAMP_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [1:0]            s_tuser,   // [1:0] mode
  input  logic [FIELD_W-1:0]    s_tdata,   // [31:0] timestamp
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [31:0] event_count, [63:32] min_ticks, [95:64] max_ticks,
  // [127:96] mean_ticks, [159:128] stddev_ticks, [160] squares_saturated
  output logic [OUT_DATA_W-1:0] m_tdata
);

  `include "interval_timing_statistics_assert.svh"

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQ   = 9'b000000010,
    S_ACC  = 9'b000000100,
    S_DIV1 = 9'b000001000,
    S_MEAN = 9'b000010000,
    S_DIV2 = 9'b000100000,
    S_VAR  = 9'b001000000,
    S_ROOT = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t                 state;
  logic [STEP_W-1:0]      step;
  logic [STAMP_WIDTH-1:0] start_stamp;
  logic [FIELD_W-1:0]     interval_count;
  logic [FIELD_W-1:0]     shortest;
  logic [FIELD_W-1:0]     longest;
  logic [WIDE_W-1:0]      tick_total;
  logic [WIDE_W-1:0]      square_total;
  logic                   square_overflow;

  logic [FIELD_W-1:0]     dur;
  logic [WIDE_W-1:0]      dq;
  logic [FIELD_W-1:0]     rem;
  logic [FIELD_W-1:0]     root;
  logic [FIELD_W-1:0]     mean;

  logic [STAMP_WIDTH-1:0] dur_next;
  logic [WIDE_W:0]        tick_sum;
  logic [WIDE_W:0]        square_sum;
  logic [FIELD_W-1:0]     mean_sat;
  logic [WIDE_W-1:0]      var_next;
  logic                   in_beat;
  logic                   out_load;
  logic                   mul_en;
  logic [FIELD_W-1:0]     mul_op;
  logic [WIDE_W-1:0]      prod;
  logic [UNIT_W-1:0]      unit_a;
  logic [UNIT_W-1:0]      unit_b;
  cmpsub_res_t            unit_res;

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // Elapsed ticks wrap at the counter width
  assign dur_next = s_tdata[STAMP_WIDTH-1:0] - start_stamp;

  // Wide accumulations with carry out for saturation
  assign tick_sum   = {1'b0, tick_total} + {{(WIDE_W + 1 - FIELD_W){1'b0}}, dur};
  assign square_sum = {1'b0, square_total} + {1'b0, prod};

  // Clamp the quotient to the mean field and form the variance
  assign mean_sat = (|dq[WIDE_W-1:FIELD_W]) ? {FIELD_W{1'b1}} : dq[FIELD_W-1:0];
  assign var_next = (dq > prod) ? (dq - prod) : '0;

  // Square the duration, later the mean
  assign mul_en = (state == S_SQ) || (state == S_MEAN);
  assign mul_op = (state == S_MEAN) ? mean_sat : dur;

  itstat_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_op),
    .b    (mul_op),
    .prod (prod)
  );

  // Root steps take two radicand bits; divide steps take one dividend bit
  always_comb begin
    if (state == S_ROOT) begin
      unit_a = {rem, dq[WIDE_W-1:WIDE_W-2]};
      unit_b = {root, 2'b01};
    end else begin
      unit_a = {1'b0, rem, dq[WIDE_W-1]};
      unit_b = {{(UNIT_W - FIELD_W){1'b0}}, interval_count};
    end
  end

  itstat_cmpsub u_cmpsub (
    .a   (unit_a),
    .b   (unit_b),
    .res (unit_res)
  );

  // Sequence events and update the statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      step            <= '0;
      start_stamp     <= '0;
      interval_count  <= '0;
      shortest        <= '0;
      longest         <= '0;
      tick_total      <= '0;
      square_total    <= '0;
      square_overflow <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            case (s_tuser)
              MODE_START: begin
                start_stamp <= s_tdata[STAMP_WIDTH-1:0];
              end
              MODE_END: begin
                state <= S_SQ;
              end
              MODE_CLEAR: begin
                start_stamp     <= '0;
                interval_count  <= '0;
                shortest        <= '0;
                longest         <= '0;
                tick_total      <= '0;
                square_total    <= '0;
                square_overflow <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SQ: begin
          tick_total <= tick_sum[WIDE_W] ? {WIDE_W{1'b1}} : tick_sum[WIDE_W-1:0];
          if (interval_count == '0) begin
            shortest <= dur;
            longest  <= dur;
          end else begin
            if (dur < shortest) begin
              shortest <= dur;
            end
            if (dur > longest) begin
              longest <= dur;
            end
          end
          if (interval_count != {FIELD_W{1'b1}}) begin
            interval_count <= interval_count + 1'b1;
          end
          state <= S_ACC;
        end
        S_ACC: begin
          if (square_sum[WIDE_W]) begin
            square_total    <= {WIDE_W{1'b1}};
            square_overflow <= 1'b1;
          end else begin
            square_total <= square_sum[WIDE_W-1:0];
          end
          step  <= DIV_LAST;
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (step == '0) begin
            state <= S_MEAN;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_MEAN: begin
          step  <= DIV_LAST;
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (step == '0) begin
            state <= S_VAR;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_VAR: begin
          step  <= ROOT_LAST;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (step == '0) begin
            state <= S_OUT;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Raise valid on a load, drop it once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Advance the shared datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        dur <= FIELD_W'(dur_next);
      end
      S_ACC: begin
        dq  <= tick_total;
        rem <= '0;
      end
      S_DIV1, S_DIV2: begin
        rem <= unit_res.ge ? unit_res.diff[FIELD_W-1:0] : unit_a[FIELD_W-1:0];
        dq  <= {dq[WIDE_W-2:0], unit_res.ge};
      end
      S_MEAN: begin
        mean <= mean_sat;
        dq   <= square_total;
        rem  <= '0;
      end
      S_VAR: begin
        dq   <= var_next;
        rem  <= '0;
        root <= '0;
      end
      S_ROOT: begin
        rem  <= unit_res.ge ? unit_res.diff[FIELD_W-1:0] : unit_a[FIELD_W-1:0];
        root <= {root[FIELD_W-2:0], unit_res.ge};
        dq   <= {dq[WIDE_W-3:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(OUT_DATA_W - 5 * FIELD_W - 1){1'b0}}, square_overflow,
                  root, mean, longest, shortest, interval_count};
    end
  end

  `ITS_ASSERT_NEXT(a_end_starts_sequence, clk, rst, in_beat && (s_tuser == MODE_END), state == S_SQ)
  `ITS_ASSERT_IMPLY(a_divisor_nonzero, clk, rst, (state == S_DIV1) || (state == S_DIV2), interval_count != '0)
  `ITS_ASSERT_IMPLY(a_min_not_above_max, clk, rst, interval_count != '0, shortest <= longest)
  `ITS_ASSERT_IMPLY(a_overflow_means_full, clk, rst, square_overflow, square_total == {WIDE_W{1'b1}})

endmodule
